// ----- hdl/kmer_diagonal_hit_chainer_top_macros.svh -----
// Assertion macros for the k-mer diagonal hit chainer.
// Used by the RTL files that check their own logic; no other dependencies.
`ifndef KMER_DIAGONAL_HIT_CHAINER_TOP_MACROS_SVH
`define KMER_DIAGONAL_HIT_CHAINER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on aclk, quiet during reset.
`define KDHC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on aclk, quiet during reset.
`define KDHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KDHC_ASSERT_IMPL(lbl, ante, cons, msg)
`define KDHC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/kdhc_pkg.sv -----
// Shared types and constants for the k-mer diagonal hit chainer.
// No dependencies.
`timescale 1ns / 1ps

package kdhc_pkg;

    localparam int DIAG_W   = 32;
    localparam int SUBJ_W   = 16;
    localparam int POS_W    = 32;
    localparam int QUERY_W  = 16;
    localparam int DIST_W   = 32;
    localparam int KMER_W   = 8;
    localparam int SCORE_W  = 32;
    localparam int COUNT_W  = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int HITS_W   = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_NUMBER        = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_DISTANCE    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH         = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAGMENT_LENGTH = 4'd3;

    localparam logic [KMER_W-1:0] KMER_LENGTH_RESET = 8'd15;

    // Lists of this many hits or fewer report nothing at their end.
    localparam logic [HITS_W-1:0] SHORT_LIST_HITS = 2'd2;
    localparam logic [HITS_W-1:0] HIT_COUNT_MAX   = 2'd3;

    typedef struct packed {
        logic signed [DIAG_W-1:0] diagonal;
        logic [SUBJ_W-1:0]        subject;
        logic [POS_W-1:0]         position;
        logic                     last;
    } hit_t;

    typedef struct packed {
        logic [POS_W-1:0]         start;
        logic [POS_W-1:0]         stop;
        logic signed [DIAG_W-1:0] diagonal;
        logic [SCORE_W-1:0]       score;
        logic [SUBJ_W-1:0]        subject;
        logic [QUERY_W-1:0]       query;
        logic [COUNT_W-1:0]       number;
    } fragment_t;

    typedef struct packed {
        logic [QUERY_W-1:0] query_number;
        logic [DIST_W-1:0]  connect_distance;
        logic [KMER_W-1:0]  kmer_length;
        logic [DIST_W-1:0]  min_fragment_length;
        logic               clear_count;
    } cfg_t;

endpackage

// ----- hdl/kdhc_cfg.sv -----
// Configuration registers of the k-mer diagonal hit chainer.
// Depends on kdhc_pkg.
`timescale 1ns / 1ps

module kdhc_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [kdhc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kdhc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output kdhc_pkg::cfg_t                     cfg
);

    logic [kdhc_pkg::QUERY_W-1:0] query_reg;
    logic [kdhc_pkg::DIST_W-1:0]  dist_reg;
    logic [kdhc_pkg::KMER_W-1:0]  kmer_reg;
    logic [kdhc_pkg::DIST_W-1:0]  min_len_reg;
    logic                         clear_reg;
    logic                         wr;

    // Writes are always taken; the user must write only while the block is idle, which the block does not enforce.
    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid;

    // Register file; a write to the query number also clears the fragment count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_reg   <= '0;
            dist_reg    <= '0;
            kmer_reg    <= kdhc_pkg::KMER_LENGTH_RESET;
            min_len_reg <= '0;
            clear_reg   <= 1'b0;
        end else begin
            clear_reg <= 1'b0;
            if (wr) begin
                unique case (cfg_index)
                    kdhc_pkg::CFG_QUERY_NUMBER: begin
                        query_reg <= cfg_data[kdhc_pkg::QUERY_W-1:0];
                        clear_reg <= 1'b1;
                    end
                    kdhc_pkg::CFG_CONNECT_DISTANCE: begin
                        dist_reg <= cfg_data[kdhc_pkg::DIST_W-1:0];
                    end
                    kdhc_pkg::CFG_KMER_LENGTH: begin
                        kmer_reg <= cfg_data[kdhc_pkg::KMER_W-1:0];
                    end
                    kdhc_pkg::CFG_MIN_FRAGMENT_LENGTH: begin
                        min_len_reg <= cfg_data[kdhc_pkg::DIST_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign cfg.query_number        = query_reg;
    assign cfg.connect_distance    = dist_reg;
    assign cfg.kmer_length         = kmer_reg;
    assign cfg.min_fragment_length = min_len_reg;
    assign cfg.clear_count         = clear_reg;

endmodule

// ----- hdl/kdhc_in_reg.sv -----
// Input register stage of the k-mer diagonal hit chainer.
// Depends on kdhc_pkg.
`timescale 1ns / 1ps

module kdhc_in_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  kdhc_pkg::hit_t  s_hit,
    input  logic            advance,
    output logic            hit_valid,
    output kdhc_pkg::hit_t  hit
);

    logic           valid_reg;
    kdhc_pkg::hit_t hit_reg;

    // The stage frees up whenever its item moves on in the same cycle.
    assign s_ready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Payload is loaded on each accepted transaction.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            hit_reg <= s_hit;
        end
    end

    assign hit_valid = valid_reg;
    assign hit       = hit_reg;

endmodule

// ----- hdl/kdhc_chain.sv -----
// Chaining state and result register of the k-mer diagonal hit chainer.
// Depends on kdhc_pkg and kmer_diagonal_hit_chainer_top_macros.svh.
`timescale 1ns / 1ps
`include "kmer_diagonal_hit_chainer_top_macros.svh"

module kdhc_chain (
    input  logic                aclk,
    input  logic                aresetn,
    input  kdhc_pkg::cfg_t      cfg,
    input  logic                hit_valid,
    input  kdhc_pkg::hit_t      hit,
    output logic                advance,
    output logic                m_valid,
    input  logic                m_ready,
    output kdhc_pkg::fragment_t frag
);

    logic                          prev_valid_reg, prev_valid_next;
    logic signed [kdhc_pkg::DIAG_W-1:0] prev_diag_reg, prev_diag_next;
    logic [kdhc_pkg::SUBJ_W-1:0]   prev_subj_reg, prev_subj_next;
    logic [kdhc_pkg::POS_W-1:0]    prev_pos_reg, prev_pos_next;
    logic                          chain_open_reg, chain_open_next;
    logic [kdhc_pkg::POS_W-1:0]    chain_start_reg, chain_start_next;
    logic [kdhc_pkg::POS_W-1:0]    chain_end_reg, chain_end_next;
    logic signed [kdhc_pkg::DIAG_W-1:0] chain_diag_reg, chain_diag_next;
    logic [kdhc_pkg::SUBJ_W-1:0]   chain_subj_reg, chain_subj_next;
    logic [kdhc_pkg::SCORE_W-1:0]  chain_score_reg, chain_score_next;
    logic [kdhc_pkg::HITS_W-1:0]   hits_reg, hits_next;
    logic [kdhc_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic                          m_valid_reg;
    kdhc_pkg::fragment_t           frag_reg, frag_next;

    logic                          proc;
    logic                          link;
    logic [kdhc_pkg::POS_W:0]      reach;
    logic                          close_now;
    logic [kdhc_pkg::POS_W+1:0]    span_lhs;
    logic [kdhc_pkg::POS_W+1:0]    span_rhs;
    logic                          emit;
    logic [kdhc_pkg::HITS_W-1:0]   hits_inc;
    logic [kdhc_pkg::COUNT_W-1:0]  count_inc;

    // The result register frees up when empty or being taken.
    assign advance = !m_valid_reg || m_ready;
    assign proc    = hit_valid && advance;

    // Link test: same diagonal and subject, step within the connect distance.
    assign reach = {1'b0, prev_pos_reg} + {1'b0, cfg.connect_distance};
    assign link  = prev_valid_reg && (prev_diag_reg == hit.diagonal)
                && (prev_subj_reg == hit.subject) && (reach >= {1'b0, hit.position});

    assign hits_inc  = (hits_reg == kdhc_pkg::HIT_COUNT_MAX) ? hits_reg
                     : hits_reg + 2'd1;
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 32'd1;

    // Chain update for one hit; at most one chain closes per hit.
    always_comb begin
        chain_open_next  = chain_open_reg;
        chain_start_next = chain_start_reg;
        chain_end_next   = chain_end_reg;
        chain_diag_next  = chain_diag_reg;
        chain_subj_next  = chain_subj_reg;
        chain_score_next = chain_score_reg;
        close_now        = 1'b0;

        if (link) begin
            if (chain_open_reg) begin
                chain_end_next = hit.position;
                if (chain_score_reg != '1) begin
                    chain_score_next = chain_score_reg + 32'd1;
                end
            end else begin
                chain_open_next  = 1'b1;
                chain_start_next = prev_pos_reg;
                chain_end_next   = hit.position;
                chain_diag_next  = prev_diag_reg;
                chain_subj_next  = prev_subj_reg;
                chain_score_next = 32'd1;
            end
        end else if (prev_valid_reg && chain_open_reg) begin
            close_now       = 1'b1;
            chain_open_next = 1'b0;
        end

        prev_valid_next = 1'b1;
        prev_diag_next  = hit.diagonal;
        prev_subj_next  = hit.subject;
        prev_pos_next   = hit.position;
        hits_next       = hits_inc;

        // End of list: close a chain of a long enough list, then start afresh.
        if (hit.last) begin
            if (chain_open_next && (hits_inc > kdhc_pkg::SHORT_LIST_HITS)) begin
                close_now = 1'b1;
            end
            chain_open_next = 1'b0;
            prev_valid_next = 1'b0;
            hits_next       = '0;
        end
    end

    // Span test end + k - 1 - start >= min, rearranged to stay non-negative.
    assign span_lhs = {2'b00, chain_end_next} + {26'd0, cfg.kmer_length};
    assign span_rhs = {2'b00, chain_start_next} + {2'b00, cfg.min_fragment_length}
                    + 34'd1;
    assign emit     = close_now && (span_lhs >= span_rhs);

    // Fragment fields come from the chain as it stands after this hit.
    always_comb begin
        frag_next.start    = chain_start_next;
        frag_next.stop     = chain_end_next;
        frag_next.diagonal = chain_diag_next;
        frag_next.score    = chain_score_next;
        frag_next.subject  = chain_subj_next;
        frag_next.query    = cfg.query_number;
        frag_next.number   = count_inc;
    end

    // Chain and previous-hit state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_valid_reg  <= 1'b0;
            prev_diag_reg   <= '0;
            prev_subj_reg   <= '0;
            prev_pos_reg    <= '0;
            chain_open_reg  <= 1'b0;
            chain_start_reg <= '0;
            chain_end_reg   <= '0;
            chain_diag_reg  <= '0;
            chain_subj_reg  <= '0;
            chain_score_reg <= '0;
            hits_reg        <= '0;
        end else if (proc) begin
            prev_valid_reg  <= prev_valid_next;
            prev_diag_reg   <= prev_diag_next;
            prev_subj_reg   <= prev_subj_next;
            prev_pos_reg    <= prev_pos_next;
            chain_open_reg  <= chain_open_next;
            chain_start_reg <= chain_start_next;
            chain_end_reg   <= chain_end_next;
            chain_diag_reg  <= chain_diag_next;
            chain_subj_reg  <= chain_subj_next;
            chain_score_reg <= chain_score_next;
            hits_reg        <= hits_next;
        end
    end

    // Fragment counter: cleared by a query number write, saturating otherwise.
    always_comb begin
        count_next = count_reg;
        if (cfg.clear_count) begin
            count_next = '0;
        end else if (proc && emit) begin
            count_next = count_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= proc && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && emit) begin
            frag_reg <= frag_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign frag    = frag_reg;

    // Checks on the chaining logic.
    `KDHC_ASSERT_IMPL(a_open_needs_prev, chain_open_reg, prev_valid_reg, "open chain without previous hit")
    `KDHC_ASSERT_NEXT(a_last_clears, proc && hit.last, !prev_valid_reg && !chain_open_reg && (hits_reg == '0), "list end did not clear state")
    `KDHC_ASSERT_IMPL(a_number_nonzero, m_valid_reg, (frag_reg.number != '0) && (frag_reg.score != '0), "fragment with zero number or score")
    `KDHC_ASSERT_NEXT(a_result_from_item, !m_valid_reg && !proc, !m_valid_reg, "result appeared without an item")

endmodule

// ----- hdl/kmer_diagonal_hit_chainer_top.sv -----
// K-mer seed hit diagonal chainer, top level.
// A closing hit passes the input register, then its fragment goes to the result register.
// Throughput: one hit per cycle unless the output stalls; a single compare-and-add pass per hit.
// Reset: synchronous, active low; clears chain state and fragment count, restores configuration.
// Configuration writes are taken in every cycle and apply to hits processed after the write.
// Depends on kdhc_pkg, kdhc_cfg, kdhc_in_reg and kdhc_chain.
`timescale 1ns / 1ps

module kmer_diagonal_hit_chainer_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [kdhc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [kdhc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [kdhc_pkg::DIAG_W-1:0]    s_hit_diagonal,
    input  logic [kdhc_pkg::SUBJ_W-1:0]           s_hit_subject,
    input  logic [kdhc_pkg::POS_W-1:0]            s_hit_position,
    input  logic                                  s_last_of_list,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [kdhc_pkg::POS_W-1:0]            m_fragment_start,
    output logic [kdhc_pkg::POS_W-1:0]            m_fragment_end,
    output logic signed [kdhc_pkg::DIAG_W-1:0]    m_fragment_diagonal,
    output logic [kdhc_pkg::SCORE_W-1:0]          m_fragment_score,
    output logic [kdhc_pkg::SUBJ_W-1:0]           m_fragment_subject,
    output logic [kdhc_pkg::QUERY_W-1:0]          m_fragment_query,
    output logic [kdhc_pkg::COUNT_W-1:0]          m_fragment_number
);

    kdhc_pkg::cfg_t      cfg;
    kdhc_pkg::hit_t      s_hit;
    kdhc_pkg::hit_t      hit;
    kdhc_pkg::fragment_t frag;
    logic                hit_valid;
    logic                advance;

    // Gather the input transaction fields.
    assign s_hit.diagonal = s_hit_diagonal;
    assign s_hit.subject  = s_hit_subject;
    assign s_hit.position = s_hit_position;
    assign s_hit.last     = s_last_of_list;

    kdhc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kdhc_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_hit     (s_hit),
        .advance   (advance),
        .hit_valid (hit_valid),
        .hit       (hit)
    );

    kdhc_chain u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .hit_valid (hit_valid),
        .hit       (hit),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .frag      (frag)
    );

    // Spread the result transaction onto its ports.
    assign m_fragment_start    = frag.start;
    assign m_fragment_end      = frag.stop;
    assign m_fragment_diagonal = frag.diagonal;
    assign m_fragment_score    = frag.score;
    assign m_fragment_subject  = frag.subject;
    assign m_fragment_query    = frag.query;
    assign m_fragment_number   = frag.number;

endmodule
